// ----- sv/dqpi_pkg.sv -----
// ============================================================================
// dqpi_pkg - shared types and constants for the dual queue block
// Operation and status codes, queue defaults and the per-cell load control.
// ============================================================================
package dqpi_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int DEFAULT_NAME_BITS   = 64;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;
    localparam int NAME_W   = 64;
    localparam int RATE_W   = 32;

    // operation carried in tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_MOVE   = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_OUT_RANGE = 2'd3
    } status_t;

    // what a queue row does this cycle
    typedef enum logic [1:0] {
        Q_HOLD = 2'd0,
        Q_PUT  = 2'd1,
        Q_POP  = 2'd2
    } q_op_t;

    // what one cell loads this cycle
    typedef struct packed {
        logic load_new;
        logic take_left;
        logic take_right;
    } cell_ctrl_t;

endpackage

// ----- sv/dual_queue_positional_insert.sv -----
// ============================================================================
// dual_queue_positional_insert - two bounded queues with positional insert
// Append, insert at a 1-based position, move head across, and read back.
// ============================================================================
//
//  channel | dir | tdata fields (low bit up)             | tuser fields
//  --------+-----+---------------------------------------+---------------------
//  s_*     | in  | name_tag, rate_value, position        | kind, queue_sel
//  m_*     | out | count_selected, count_other,          | status
//          |     | read_name, read_rate                  |
//
//  Each transfer is done on the accepting edge: both queue rows of cells shift in
//  parallel and the result lands in the output register.
//  Sustained rate is one item per cycle, set by the output register handshake.
//  The input stalls only while a result waits and m_tready is low.
//  Reset clears both counts and the output valid; entry cells are not cleared,
//  so nothing needs a clearing pass.
//
module dual_queue_positional_insert
#(
    parameter int QUEUE_DEPTH = dqpi_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int NAME_BITS   = dqpi_pkg::DEFAULT_NAME_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // name_tag[63:0], rate_value[95:64], position[100:96]
    input  logic [2:0]   s_tuser,   // kind[1:0], queue_sel[2]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // count_selected[4:0], count_other[9:5],
                                    // read_name[73:10], read_rate[105:74]
    output logic [1:0]   m_tuser    // status[1:0]
);
    import dqpi_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = CNT_W + POS_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    // unpack the input transfer
    kind_t                kind;
    logic                 sel;
    logic [NAME_BITS-1:0] in_name;
    logic [31:0]          in_rate;
    logic [POS_W-1:0]     pos;

    assign kind    = kind_t'(s_tuser[1:0]);
    assign sel     = s_tuser[2];
    assign in_name = s_tdata[NAME_BITS-1:0];
    assign in_rate = s_tdata[95:64];
    assign pos     = s_tdata[100:96];

    logic accept;
    assign accept = s_tvalid && s_tready;

    // queue row hookup, index 0 is queue A
    q_op_t                q_op       [2];
    logic [CNT_W-1:0]     q_put_idx  [2];
    logic [NAME_BITS-1:0] q_put_name [2];
    logic [31:0]          q_put_rate [2];
    logic [CNT_W-1:0]     q_count    [2];
    logic [NAME_BITS-1:0] q_head_name[2];
    logic [31:0]          q_head_rate[2];
    logic [NAME_BITS-1:0] q_rd_name  [2];
    logic [31:0]          q_rd_rate  [2];
    logic [CNT_W-1:0]     rd_idx;

    for (genvar q = 0; q < 2; q++)
    begin : g_queue
        dqpi_queue #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .NAME_BITS   (NAME_BITS),
            .CNT_W       (CNT_W)
        ) u_queue (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (q_op[q]),
            .put_idx   (q_put_idx[q]),
            .put_name  (q_put_name[q]),
            .put_rate  (q_put_rate[q]),
            .rd_idx    (rd_idx),
            .count     (q_count[q]),
            .head_name (q_head_name[q]),
            .head_rate (q_head_rate[q]),
            .rd_name   (q_rd_name[q]),
            .rd_rate   (q_rd_rate[q])
        );
    end

    // decode the operation against the current counts
    logic [CNT_W-1:0]     cnt_sel;
    logic [CNT_W-1:0]     cnt_oth;
    logic [CNT_W-1:0]     cnt_sel_after;
    logic [CNT_W-1:0]     cnt_oth_after;
    logic [POS_W-1:0]     pos_m1;
    logic [EXT_W-1:0]     pos_m1_ext;
    logic [EXT_W-1:0]     cnt_sel_ext;
    logic [CNT_W-1:0]     ins_idx;
    q_op_t                op_sel;
    q_op_t                op_oth;
    status_t              status;
    logic [NAME_BITS-1:0] rd_name;
    logic [31:0]          rd_rate;

    always_comb
    begin
        cnt_sel     = sel ? q_count[1] : q_count[0];
        cnt_oth     = sel ? q_count[0] : q_count[1];
        // treat position zero as the head
        pos_m1      = (pos == '0) ? '0 : pos - POS_W'(1);
        pos_m1_ext  = EXT_W'(pos_m1);
        cnt_sel_ext = EXT_W'(cnt_sel);
        rd_idx      = pos_m1_ext[CNT_W-1:0];
        ins_idx     = (pos_m1_ext > cnt_sel_ext) ? cnt_sel : pos_m1_ext[CNT_W-1:0];

        op_sel        = Q_HOLD;
        op_oth        = Q_HOLD;
        status        = ST_DONE;
        cnt_sel_after = cnt_sel;
        cnt_oth_after = cnt_oth;
        rd_name       = '0;
        rd_rate       = '0;

        unique case (kind) inside
            KIND_APPEND, KIND_INSERT:
            begin
                if (cnt_sel >= FULL_CNT)
                    status = ST_FULL;
                else
                begin
                    op_sel        = Q_PUT;
                    cnt_sel_after = cnt_sel + CNT_W'(1);
                end
                if (kind == KIND_APPEND)
                    ins_idx = cnt_sel;
            end
            KIND_MOVE:
            begin
                // empty source wins over a full destination
                if (cnt_sel == '0)
                    status = ST_EMPTY;
                else if (cnt_oth >= FULL_CNT)
                    status = ST_FULL;
                else
                begin
                    op_sel        = Q_POP;
                    op_oth        = Q_PUT;
                    cnt_sel_after = cnt_sel - CNT_W'(1);
                    cnt_oth_after = cnt_oth + CNT_W'(1);
                end
            end
            KIND_READ:
            begin
                if (pos_m1_ext >= cnt_sel_ext)
                    status = ST_OUT_RANGE;
                else
                begin
                    rd_name = sel ? q_rd_name[1] : q_rd_name[0];
                    rd_rate = sel ? q_rd_rate[1] : q_rd_rate[0];
                end
            end
            default:
            begin
                status = ST_DONE;
            end
        endcase
    end

    // steer ops and put data to the physical rows; hold unless a transfer lands
    always_comb
    begin
        for (int q = 0; q < 2; q++)
        begin
            if ((q == 1) == sel)
            begin
                q_op[q]       = accept ? op_sel : Q_HOLD;
                q_put_idx[q]  = ins_idx;
                q_put_name[q] = in_name;
                q_put_rate[q] = in_rate;
            end
            else
            begin
                q_op[q]       = accept ? op_oth : Q_HOLD;
                q_put_idx[q]  = cnt_oth;
                q_put_name[q] = sel ? q_head_name[1] : q_head_name[0];
                q_put_rate[q] = sel ? q_head_rate[1] : q_head_rate[0];
            end
        end
    end

    // output register
    logic                 m_tvalid_reg;
    status_t              status_reg;
    logic [COUNT_W-1:0]   cnt_sel_reg;
    logic [COUNT_W-1:0]   cnt_oth_reg;
    logic [NAME_BITS-1:0] rd_name_reg;
    logic [31:0]          rd_rate_reg;
    logic [EXT_W-1:0]     cnt_sel_after_ext;
    logic [EXT_W-1:0]     cnt_oth_after_ext;

    assign cnt_sel_after_ext = EXT_W'(cnt_sel_after);
    assign cnt_oth_after_ext = EXT_W'(cnt_oth_after);

    // take a new transfer whenever the held result leaves or none is held
    assign s_tready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (s_tready)
            m_tvalid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status;
            cnt_sel_reg <= cnt_sel_after_ext[COUNT_W-1:0];
            cnt_oth_reg <= cnt_oth_after_ext[COUNT_W-1:0];
            rd_name_reg <= rd_name;
            rd_rate_reg <= rd_rate;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {6'd0, rd_rate_reg, NAME_W'(rd_name_reg), cnt_oth_reg, cnt_sel_reg};

endmodule

// ----- sv/dqpi_cell.sv -----
// ============================================================================
// dqpi_cell - one entry slot of a queue row
// Holds a name and a rate; loads a new entry or a neighbor's entry.
// ============================================================================
module dqpi_cell #(
    parameter int NAME_BITS = dqpi_pkg::DEFAULT_NAME_BITS
) (
    input  logic                   clk,
    input  dqpi_pkg::cell_ctrl_t   ctrl,
    input  logic [NAME_BITS-1:0]   new_name,
    input  logic [31:0]            new_rate,
    input  logic [NAME_BITS-1:0]   left_name,
    input  logic [31:0]            left_rate,
    input  logic [NAME_BITS-1:0]   right_name,
    input  logic [31:0]            right_rate,
    output logic [NAME_BITS-1:0]   name,
    output logic [31:0]            rate
);
    import dqpi_pkg::*;

    logic [NAME_BITS-1:0] name_reg;
    logic [31:0]          rate_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_new)
        begin
            name_reg <= new_name;
            rate_reg <= new_rate;
        end
        else if (ctrl.take_left)
        begin
            name_reg <= left_name;
            rate_reg <= left_rate;
        end
        else if (ctrl.take_right)
        begin
            name_reg <= right_name;
            rate_reg <= right_rate;
        end
    end

    assign name = name_reg;
    assign rate = rate_reg;

endmodule

// ----- sv/dqpi_queue.sv -----
// ============================================================================
// dqpi_queue - one bounded queue as a row of cells
// Put opens a gap at an index by shifting the tail right; pop shifts left.
// ============================================================================
module dqpi_queue #(
    parameter int QUEUE_DEPTH = dqpi_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int NAME_BITS   = dqpi_pkg::DEFAULT_NAME_BITS,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dqpi_pkg::q_op_t        op,
    input  logic [CNT_W-1:0]       put_idx,
    input  logic [NAME_BITS-1:0]   put_name,
    input  logic [31:0]            put_rate,
    input  logic [CNT_W-1:0]       rd_idx,
    output logic [CNT_W-1:0]       count,
    output logic [NAME_BITS-1:0]   head_name,
    output logic [31:0]            head_rate,
    output logic [NAME_BITS-1:0]   rd_name,
    output logic [31:0]            rd_rate
);
    import dqpi_pkg::*;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [NAME_BITS-1:0] cell_name [QUEUE_DEPTH];
    logic [31:0]          cell_rate [QUEUE_DEPTH];

    always_comb
    begin
        count_next = count_reg;
        case (op)
            Q_PUT:   count_next = count_reg + CNT_W'(1);
            Q_POP:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    for (genvar k = 0; k < QUEUE_DEPTH; k++)
    begin : g_cell
        localparam logic [CNT_W-1:0] K = CNT_W'(k);
        cell_ctrl_t           ctrl;
        logic [NAME_BITS-1:0] l_name;
        logic [31:0]          l_rate;
        logic [NAME_BITS-1:0] r_name;
        logic [31:0]          r_rate;

        assign ctrl.load_new   = (op == Q_PUT) && (put_idx == K);
        assign ctrl.take_left  = (op == Q_PUT) && (put_idx < K);
        assign ctrl.take_right = (op == Q_POP);

        if (k == 0)
        begin : g_first
            assign l_name = put_name;
            assign l_rate = put_rate;
        end
        else
        begin : g_inner_l
            assign l_name = cell_name[k-1];
            assign l_rate = cell_rate[k-1];
        end

        if (k == QUEUE_DEPTH - 1)
        begin : g_last
            assign r_name = cell_name[k];
            assign r_rate = cell_rate[k];
        end
        else
        begin : g_inner_r
            assign r_name = cell_name[k+1];
            assign r_rate = cell_rate[k+1];
        end

        dqpi_cell #(
            .NAME_BITS (NAME_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_name   (put_name),
            .new_rate   (put_rate),
            .left_name  (l_name),
            .left_rate  (l_rate),
            .right_name (r_name),
            .right_rate (r_rate),
            .name       (cell_name[k]),
            .rate       (cell_rate[k])
        );
    end

    // select the addressed cell onto the read bus
    always_comb
    begin
        rd_name = '0;
        rd_rate = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            if (rd_idx == CNT_W'(k))
            begin
                rd_name = rd_name | cell_name[k];
                rd_rate = rd_rate | cell_rate[k];
            end
        end
    end

    assign count     = count_reg;
    assign head_name = cell_name[0];
    assign head_rate = cell_rate[0];

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top - self-checking bench for dual_queue_positional_insert
// Streams append, insert, move and read transfers into the block with random
// gaps on both sides. A shadow copy of both queues predicts every result, and
// each result is checked field by field against the oldest prediction.
// ============================================================================
module tb_top;

    import dqpi_pkg::*;

    localparam int          DEPTH        = DEFAULT_QUEUE_DEPTH;
    localparam int          RANDOM_OPS   = 1100;
    localparam int          MAX_WAIT     = 12;
    localparam logic signed [RATE_W-1:0] RATE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [RATE_W-1:0] RATE_MIN = 32'sh8000_0000;

    // one input transfer plus its sender-side timing
    typedef struct {
        kind_t                     kind;
        logic                      sel;
        logic [NAME_W-1:0]         name_tag;
        logic signed [RATE_W-1:0]  rate_value;
        logic [POS_W-1:0]          position;
        int unsigned               gap;
        bit                        drain;
    } queue_op_t;

    typedef struct {
        status_t                   status;
        logic [COUNT_W-1:0]        count_sel;
        logic [COUNT_W-1:0]        count_oth;
        logic [NAME_W-1:0]         read_name;
        logic signed [RATE_W-1:0]  read_rate;
    } queue_result_t;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [1:0]   m_tuser;

    // shadow of the block's two queues
    logic [NAME_W-1:0]        entry_names [2][DEPTH];
    logic signed [RATE_W-1:0] entry_rates [2][DEPTH];
    int unsigned              entry_count [2] = '{0, 0};

    queue_op_t     op_backlog [$];
    queue_result_t predicted_results [$];

    // entry counts as the stimulus plan sees them, used only to shape items
    int unsigned plan_count [2] = '{0, 0};
    bit          sender_burst = 1'b0;

    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned error_count  = 0;
    bit          feed_done    = 1'b0;

    dual_queue_positional_insert i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #400_000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // open a hole at slot by shifting the tail up, then fill it
    function automatic void place_entry(int unsigned q, int unsigned slot,
                                        logic [NAME_W-1:0] name,
                                        logic signed [RATE_W-1:0] rate);
        int unsigned k;
        for (k = entry_count[q]; k > slot; k--)
        begin
            entry_names[q][k] = entry_names[q][k-1];
            entry_rates[q][k] = entry_rates[q][k-1];
        end
        entry_names[q][slot] = name;
        entry_rates[q][slot] = rate;
        entry_count[q]++;
    endfunction

    function automatic queue_result_t apply_queue_op(queue_op_t op);
        queue_result_t            r;
        int unsigned              src;
        int unsigned              dst;
        int unsigned              slot;
        int unsigned              k;
        logic [NAME_W-1:0]        head_name;
        logic signed [RATE_W-1:0] head_rate;
        src         = op.sel;
        dst         = src ^ 1;
        // position zero behaves as position one
        slot        = (op.position == 0) ? 0 : op.position - 1;
        r.status    = ST_DONE;
        r.read_name = '0;
        r.read_rate = '0;
        case (op.kind)
            KIND_APPEND, KIND_INSERT:
            begin
                if (entry_count[src] >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    if (op.kind == KIND_APPEND || slot > entry_count[src])
                        slot = entry_count[src];
                    place_entry(src, slot, op.name_tag, op.rate_value);
                end
            end
            KIND_MOVE:
            begin
                // an empty source wins over a full destination
                if (entry_count[src] == 0)
                    r.status = ST_EMPTY;
                else if (entry_count[dst] >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    head_name = entry_names[src][0];
                    head_rate = entry_rates[src][0];
                    for (k = 1; k < entry_count[src]; k++)
                    begin
                        entry_names[src][k-1] = entry_names[src][k];
                        entry_rates[src][k-1] = entry_rates[src][k];
                    end
                    entry_count[src]--;
                    place_entry(dst, entry_count[dst], head_name, head_rate);
                end
            end
            default:
            begin
                if (slot >= entry_count[src])
                    r.status = ST_OUT_RANGE;
                else
                begin
                    r.read_name = entry_names[src][slot];
                    r.read_rate = entry_rates[src][slot];
                end
            end
        endcase
        r.count_sel = COUNT_W'(entry_count[src]);
        r.count_oth = COUNT_W'(entry_count[dst]);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic logic signed [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 7))
            0:       return RATE_MAX;
            1:       return RATE_MIN;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // queue one item; keep the planned counts in step so later items can aim
    function automatic void add_op(kind_t kind, logic sel, logic [NAME_W-1:0] name,
                                   logic signed [RATE_W-1:0] rate,
                                   logic [POS_W-1:0] pos, bit drain);
        queue_op_t   op;
        int unsigned oth;
        oth           = sel ^ 1;
        op.kind       = kind;
        op.sel        = sel;
        op.name_tag   = name;
        op.rate_value = rate;
        op.position   = pos;
        op.drain      = drain;
        op.gap        = sender_burst ? 0 : $urandom_range(0, MAX_WAIT);
        op_backlog.push_back(op);
        if (kind == KIND_APPEND || kind == KIND_INSERT)
        begin
            if (plan_count[sel] < DEPTH)
                plan_count[sel]++;
        end
        else if (kind == KIND_MOVE && plan_count[sel] > 0 && plan_count[oth] < DEPTH)
        begin
            plan_count[sel]--;
            plan_count[oth]++;
        end
    endfunction

    initial
    begin : stimulus
        int          i;
        int unsigned cap;
        int unsigned pick;
        logic        sel;
        kind_t       kind;
        logic [POS_W-1:0] pos;

        // fill queue B through every placement rule, extremes of name and rate first
        add_op(KIND_APPEND, 1'b1, '1, RATE_MAX, 5'd1, 1'b0);
        add_op(KIND_APPEND, 1'b1, '0, RATE_MIN, 5'd1, 1'b0);
        add_op(KIND_INSERT, 1'b1, "HEADNAME", -1, 5'd0, 1'b0);   // zero means head
        add_op(KIND_INSERT, 1'b1, "MIDDLE__", '0, 5'd2, 1'b0);
        add_op(KIND_INSERT, 1'b1, "TAILWARD", 1, 5'd31, 1'b0);   // beyond the count
        add_op(KIND_INSERT, 1'b1, "FRONT___", pick_rate(), 5'd1, 1'b0);
        for (i = 0; i < 10; i++)
            add_op((i % 2 == 0) ? KIND_INSERT : KIND_APPEND, 1'b1,
                   {$urandom, $urandom}, pick_rate(), 5'($urandom_range(0, 31)), 1'b0);
        // B is full now
        add_op(KIND_APPEND, 1'b1, {$urandom, $urandom}, pick_rate(), 5'd1, 1'b0);
        add_op(KIND_INSERT, 1'b1, {$urandom, $urandom}, pick_rate(), 5'd1, 1'b0);
        add_op(KIND_MOVE,   1'b0, '0, '0, 5'd0, 1'b0);       // A empty and B full
        add_op(KIND_APPEND, 1'b0, "ONLY_IN_", RATE_MIN, 5'd0, 1'b0);
        add_op(KIND_MOVE,   1'b0, '0, '0, 5'd0, 1'b0);       // destination full
        add_op(KIND_READ,   1'b1, '0, '0, 5'd0, 1'b0);
        add_op(KIND_READ,   1'b1, '0, '0, 5'd16, 1'b0);
        add_op(KIND_READ,   1'b1, '0, '0, 5'd17, 1'b0);
        add_op(KIND_MOVE,   1'b1, '0, '0, 5'd0, 1'b0);

        // Random part: let the total fill level creep up so the end of the run
        // sits on full queues, while moves keep reshuffling the split.
        for (i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 40 == 0)
                sender_burst = ($urandom_range(0, 3) == 0);
            cap  = 17 + (i * 16) / 900;
            sel  = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                kind = $urandom_range(0, 1) ? KIND_INSERT : KIND_APPEND;
                if (plan_count[0] + plan_count[1] >= cap && plan_count[sel] < DEPTH)
                    kind = KIND_READ;
            end
            else if (pick < 60)
                kind = KIND_MOVE;
            else
                kind = KIND_READ;
            if ($urandom_range(0, 9) < 2)
                pos = POS_W'($urandom_range(0, 31));
            else
                pos = POS_W'($urandom_range(0, plan_count[sel] +
                                               ((kind == KIND_INSERT) ? 1 : 0)));
            add_op(kind, sel, {$urandom, $urandom}, pick_rate(), pos,
                   (i == 0) || ($urandom_range(0, 199) == 0));
        end
    end

    // ------------------------------------------------------------------------
    // Driver: present one item at a time, honoring its gap and drain request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : feed
        queue_op_t   live_op;
        queue_op_t   staged_op;
        bit          staged;
        bit          presenting;
        bit          accepted;
        int unsigned gap_left;
        if (rst_n)
        begin
            presenting = s_tvalid;
            accepted   = s_tvalid && s_tready;
            if (accepted)
            begin
                predicted_results.push_back(apply_queue_op(live_op));
                items_sent <= items_sent + 1;
                presenting = 1'b0;
            end
            if (!presenting)
            begin
                if (!staged && op_backlog.size() != 0)
                begin
                    staged_op = op_backlog.pop_front();
                    staged    = 1'b1;
                    gap_left  = staged_op.gap;
                end
                if (staged)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    // a drain item holds until every result is back
                    else if (!staged_op.drain || (!accepted && items_sent == results_seen))
                    begin
                        live_op = staged_op;
                        s_tdata <= {3'b000, live_op.position, live_op.rate_value,
                                    live_op.name_tag};
                        s_tuser <= {live_op.sel, live_op.kind};
                        presenting = 1'b1;
                        staged     = 1'b0;
                    end
                end
            end
            s_tvalid  <= presenting;
            feed_done <= !presenting && !staged && op_backlog.size() == 0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stall at random, check every result transfer
    // ------------------------------------------------------------------------
    task automatic report_field(string what, logic [NAME_W-1:0] want, logic [NAME_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : observe
        queue_result_t want;
        int unsigned   stall_left;
        bit            calm;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, expected none, actual %h/%h",
                             $time, m_tuser, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    report_field("status", want.status, m_tuser);
                    report_field("count_selected", want.count_sel, m_tdata[4:0]);
                    report_field("count_other", want.count_oth, m_tdata[9:5]);
                    report_field("read_name", want.read_name, m_tdata[73:10]);
                    // compare the raw rate bits, no sign extension
                    report_field("read_rate", $unsigned(want.read_rate), m_tdata[105:74]);
                end
                // switch between stretches of full rate and random stalls
                if (results_seen % 64 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                stall_left = calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else if (stall_left != 0)
                stall_left--;
            m_tready <= (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------------
    // End of run
    // ------------------------------------------------------------------------
    initial
    begin : finish_run
        @(posedge rst_n);
        do
            @(negedge clk);
        while (!(feed_done && !s_tvalid && predicted_results.size() == 0));
        // give any stray result time to show up
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (predicted_results.size() != 0)
        begin
            $display("%0t: results never arrived, expected %0d more, actual 0",
                     $time, predicted_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/dqpi_pkg.sv
sv/dqpi_cell.sv
sv/dqpi_queue.sv
sv/dual_queue_positional_insert.sv
verif/tb_top.sv
